FILE: design/positional_array_list_assert.svh
// assertion helpers for the positional array list
// each macro expects clk and arst_n in scope
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// same-cycle implication
`define PAL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pal: same-cycle check failed");

// next-cycle implication
`define PAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pal: next-cycle check failed");

`endif

FILE: design/pal_pkg.sv
package pal_pkg;

	localparam int POS_W     = 8;
	localparam int VAL_W     = 32;
	localparam int FIDX_W    = 7;
	localparam int LEN_W     = 8;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic              ins;    // insert: load at pos0, shift up above it
		logic              del;    // delete: shift down from pos0 upward
		logic              cap;    // capture compare result into hit flag
		logic              shift;  // move hit flags one cell toward cell 0
		logic [POS_W-1:0]  pos0;   // 0-based position
		logic [VAL_W-1:0]  value;  // value to insert or search key
	} pal_ctrl_t;

endpackage

FILE: design/pal_if.sv
interface pal_req_if import pal_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               status;
	logic [FIDX_W-1:0]  found_index;
	logic [LEN_W-1:0]   length;
	logic               empty_res;
	logic               full_res;

	modport source (output valid, status, found_index, length, empty_res, full_res,
		input ready);
	modport sink   (input valid, status, found_index, length, empty_res, full_res,
		output ready);
endinterface

FILE: design/pal_cell.sv
module pal_cell import pal_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  pal_ctrl_t         ctrl,
	input  logic [VAL_W-1:0]  left_data,
	input  logic [VAL_W-1:0]  right_data,
	input  logic              right_hit,
	output logic [VAL_W-1:0]  data_q,
	output logic              hit_q
);

	logic at_pos;
	logic above_pos;

	assign at_pos    = (int'(ctrl.pos0) == IDX);
	assign above_pos = (int'(ctrl.pos0) < IDX);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (at_pos) begin
				data_q <= ctrl.value;
			end else if (above_pos) begin
				data_q <= left_data;
			end
		end else if (ctrl.del) begin
			if (at_pos || above_pos) begin
				data_q <= right_data;
			end
		end
	end

	// hit flags form a shift line toward cell 0 during a search
	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			hit_q <= (data_q == ctrl.value);
		end else if (ctrl.shift) begin
			hit_q <= right_hit;
		end
	end

endmodule

FILE: design/positional_array_list.sv
// channel | dir | payload                                        | role
// req     | in  | cmd, position, value                           | one command per item
// rsp     | out | status, found_index, length, empty_res, full_res | one result per item
//
// insert, delete and clear finish in the cycle the item is taken
// find compares the key in every cell, then walks the hit flags toward cell 0 along
// the shift line until a hit or the last entry; count == 0 answers at once
// arst_n clears the count, the scan state and the result valid; list cells hold junk
// a stalled rsp holds the result register; req is taken only while it is free or drains
module positional_array_list import pal_pkg::*; #(
	parameter int DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	pal_req_if.sink     req,
	pal_rsp_if.source   rsp
);

	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// control states
	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IW-1:0]      idx_q;      // list index whose hit flag sits in cell 0

	// result register
	logic               valid_q;
	logic               status_q;
	logic [FIDX_W-1:0]  found_q;
	logic [LEN_W-1:0]   length_q;
	logic               empty_q;
	logic               full_q;

	pal_ctrl_t          ctrl;
	logic [VAL_W-1:0]   data_w [DEPTH];
	logic [DEPTH-1:0]   hit_w;

	logic               out_free;
	logic               acc;
	logic               ins_ok;
	logic               del_ok;
	logic               find_scan;   // find that needs the walk
	logic               done_now;    // result written in the accept cycle
	logic               res_status;
	logic [CNT_W-1:0]   count_nxt;
	logic               scan_hit;
	logic               scan_last;
	logic               scan_done;

	assign out_free  = !valid_q || rsp.ready;
	assign req.ready = (state_q == ST_RUN) && out_free;
	assign acc       = req.valid && req.ready;

	// range checks on the 1-based position
	assign ins_ok = (req.position != '0)
		&& (int'(req.position) <= int'(count_q) + 1)
		&& (count_q != CNT_W'(DEPTH));
	assign del_ok = (req.position != '0)
		&& (int'(req.position) <= int'(count_q));

	assign find_scan = (req.cmd == CMD_FIND) && (count_q != '0);
	assign done_now  = acc && !find_scan;

	// next count and status for commands that finish when taken
	always_comb begin
		count_nxt  = count_q;
		res_status = 1'b0;
		case (req.cmd)
			CMD_INSERT: begin
				res_status = !ins_ok;
				if (ins_ok) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				res_status = !del_ok;
				if (del_ok) begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			CMD_FIND: begin
				res_status = 1'b1;  // only reached here on an empty list
			end
			CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	// search walk: cell 0 holds the hit flag of list index idx_q
	assign scan_hit  = hit_w[0];
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) >= count_q);
	assign scan_done = (state_q == ST_SCAN) && out_free && (scan_hit || scan_last);

	// broadcast to the chain
	always_comb begin
		ctrl.ins   = acc && (req.cmd == CMD_INSERT) && ins_ok;
		ctrl.del   = acc && (req.cmd == CMD_DELETE) && del_ok;
		ctrl.cap   = acc && find_scan;
		ctrl.shift = (state_q == ST_SCAN) && out_free && !scan_hit && !scan_last;
		ctrl.pos0  = req.position - POS_W'(1);
		ctrl.value = req.value;
	end

	// row of cells, one list entry each
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_d;
		logic [VAL_W-1:0] right_d;
		logic             right_h;

		if (i == 0) begin : g_first
			assign left_d = ctrl.value;  // cell 0 never takes from the left
		end else begin : g_mid_l
			assign left_d = data_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
			assign right_h = 1'b0;
		end else begin : g_mid_r
			assign right_d = data_w[i+1];
			assign right_h = hit_w[i+1];
		end

		pal_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.left_data (left_d),
			.right_data(right_d),
			.right_hit (right_h),
			.data_q    (data_w[i]),
			.hit_q     (hit_w[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			count_q <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (acc) begin
						count_q <= count_nxt;
						if (find_scan) begin
							state_q <= ST_SCAN;
							idx_q   <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_RUN;
					end else if (ctrl.shift) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase

			if (done_now || scan_done) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (done_now) begin
			status_q <= res_status;
			found_q  <= '0;
			length_q <= LEN_W'(count_nxt);
			empty_q  <= (count_nxt == '0);
			full_q   <= (count_nxt == CNT_W'(DEPTH));
		end else if (scan_done) begin
			status_q <= !scan_hit;
			found_q  <= scan_hit ? FIDX_W'(idx_q) : '0;
			length_q <= LEN_W'(count_q);
			empty_q  <= (count_q == '0);
			full_q   <= (count_q == CNT_W'(DEPTH));
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_index = found_q;
	assign rsp.length      = length_q;
	assign rsp.empty_res   = empty_q;
	assign rsp.full_res    = full_q;

	`include "positional_array_list_assert.svh"

	`PAL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`PAL_ASSERT_NOW(a_no_take_in_scan, state_q == ST_SCAN, !req.ready)
	`PAL_ASSERT_NEXT(a_clear_empties, acc && (req.cmd == CMD_CLEAR), (count_q == '0) && rsp.valid && rsp.empty_res)

endmodule

FILE: test/tb_positional_array_list.sv
module tb_positional_array_list import pal_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 128;
	localparam int RAND_ITEMS   = 1530;
	localparam int LIMIT_CYCLES = 1000000;
	// a find walks at most DEPTH list entries, so this covers any item still in flight
	localparam int TAIL_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;

	// one command as it goes onto the request channel
	typedef struct {
		logic [1:0]              cmd;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		bit                      wait_drain;  // hold until every result is back
	} list_cmd_t;

	// one result as the list reports it
	typedef struct packed {
		logic              status;
		logic [FIDX_W-1:0] found_index;
		logic [LEN_W-1:0]  length;
		logic              empty_res;
		logic              full_res;
	} list_result_t;

	// stimulus shaping: how the random part leans from one stretch to the next
	typedef enum int {EP_GROW, EP_SHRINK, EP_MIX, EP_FILL} episode_t;

	logic clk;
	logic arst_n;

	pal_req_if req_if();
	pal_rsp_if rsp_if();

	positional_array_list #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// pending commands for the driver, and results still owed by the list
	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];

	// planner's picture of the list contents, used only to aim positions and keys
	logic signed [VAL_W-1:0] planned_vals[$];

	// predictor state
	logic signed [VAL_W-1:0] model_cells[DEPTH];
	int                      model_len;

	// corner values that insert and find draw from
	logic signed [VAL_W-1:0] corner_vals[6] = '{
		32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0, 32'sd1, 32'sh5555_5555
	};

	int  total_cmds;
	int  sent_cnt;
	int  fail_cnt;
	int  cycle_cnt;
	bit  req_fire;

	// clock: 8 ns period
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor: applies one command to the list copy and returns the result
	// ------------------------------------------------------------------
	function automatic list_result_t apply_list_cmd(list_cmd_t it);
		list_result_t r;
		int           p;
		p = int'(it.position);
		r = '0;
		case (it.cmd)
			CMD_INSERT: begin
				// out of range or full list: rejected, list untouched
				if (p == 0 || p > model_len + 1 || model_len >= DEPTH) begin
					r.status = 1'b1;
				end else begin
					for (int i = model_len; i >= p; i--)
						model_cells[i] = model_cells[i - 1];
					model_cells[p - 1] = it.value;
					model_len++;
				end
			end
			CMD_DELETE: begin
				// position 0, past the end, or any delete on an empty list
				if (p == 0 || p > model_len) begin
					r.status = 1'b1;
				end else begin
					for (int i = p; i < model_len; i++)
						model_cells[i - 1] = model_cells[i];
					model_len--;
				end
			end
			CMD_FIND: begin
				// lowest matching index wins; no match leaves the index at zero
				r.status = 1'b1;
				for (int i = 0; i < model_len; i++) begin
					if (model_cells[i] == it.value) begin
						r.status      = 1'b0;
						r.found_index = FIDX_W'(i);
						break;
					end
				end
			end
			CMD_CLEAR: begin
				// cells keep their bits, only the length drops
				model_len = 0;
			end
			default: ;
		endcase
		r.length    = LEN_W'(model_len);
		r.empty_res = (model_len == 0);
		r.full_res  = (model_len == DEPTH);
		return r;
	endfunction

	// idle rates per third of the run: sender-light, receiver-light, then none
	function automatic int send_idle_pct();
		if (sent_cnt < total_cmds / 3)
			return 31;
		else if (sent_cnt < 2 * total_cmds / 3)
			return 65;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (sent_cnt < total_cmds / 3)
			return 65;
		else if (sent_cnt < 2 * total_cmds / 3)
			return 31;
		return 0;
	endfunction

	task automatic note_failure(string msg);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// stimulus planning
	// ------------------------------------------------------------------

	// queue one command and keep the planner's picture of the list in step
	task automatic plan_cmd(logic [1:0] c, int pos, logic signed [VAL_W-1:0] v, bit drain);
		list_cmd_t it;
		int        n;
		n             = planned_vals.size();
		it.cmd        = c;
		it.position   = POS_W'(pos);
		it.value      = v;
		it.wait_drain = drain;
		pending_cmds.push_back(it);
		case (c)
			CMD_INSERT: if (pos >= 1 && pos <= n + 1 && n < DEPTH)
				planned_vals.insert(pos - 1, v);
			CMD_DELETE: if (pos >= 1 && pos <= n)
				planned_vals.delete(pos - 1);
			CMD_CLEAR:  planned_vals.delete();
			default: ;
		endcase
	endtask

	// keys for finds mostly come from the list itself so that hits are common
	function automatic logic signed [VAL_W-1:0] pick_value(bit for_find);
		int r;
		r = $urandom_range(99);
		if (planned_vals.size() != 0 && r < (for_find ? 60 : 30))
			return planned_vals[$urandom_range(planned_vals.size() - 1)];
		if (r < 70)
			return corner_vals[$urandom_range(5)];
		return $urandom;
	endfunction

	// one random command, weighted by the current stretch
	task automatic plan_random_cmd(episode_t ep, bit drain);
		int         n;
		int         r;
		int         ins_w;
		int         del_w;
		int         find_w;
		int         pos;
		bit         noise;
		logic [1:0] c;
		n = planned_vals.size();
		case (ep)
			EP_GROW:   begin ins_w = 65; del_w = 77; find_w = 100; end
			EP_SHRINK: begin ins_w = 15; del_w = 65; find_w = 98;  end
			default:   begin ins_w = 40; del_w = 70; find_w = 98;  end
		endcase
		r = $urandom_range(99);
		if (r < ins_w)
			c = CMD_INSERT;
		else if (r < del_w)
			c = CMD_DELETE;
		else if (r < find_w)
			c = CMD_FIND;
		else
			c = CMD_CLEAR;
		// a few positions anywhere in the field, mostly rejected ones
		noise = ($urandom_range(99) < 8);
		case (c)
			CMD_INSERT: pos = noise ? $urandom_range(255) : $urandom_range(1, n + 1);
			CMD_DELETE: pos = (noise || n == 0) ? $urandom_range(255) : $urandom_range(1, n);
			default:    pos = $urandom_range(255);
		endcase
		plan_cmd(c, pos, pick_value(c == CMD_FIND), drain);
	endtask

	// ------------------------------------------------------------------
	// request driver: changes on the falling edge, holds an item until taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		list_cmd_t nxt;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_fire) begin
			// a drain marker holds the next item back until the list has answered everything
			if (pending_cmds.size() != 0
					&& !(pending_cmds[0].wait_drain && expected_results.size() != 0)
					&& $urandom_range(99) >= send_idle_pct()) begin
				nxt = pending_cmds.pop_front();
				req_if.valid    <= 1'b1;
				req_if.cmd      <= nxt.cmd;
				req_if.position <= nxt.position;
				req_if.value    <= nxt.value;
				sent_cnt++;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
		// response back-pressure
		rsp_if.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct());
	end

	// ------------------------------------------------------------------
	// monitor: samples both channels on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		list_cmd_t    taken;
		list_result_t want;
		list_result_t got;
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			req_fire <= req_if.valid && req_if.ready;
			// every accepted command owes exactly one result
			if (req_if.valid && req_if.ready) begin
				taken.cmd        = req_if.cmd;
				taken.position   = req_if.position;
				taken.value      = req_if.value;
				taken.wait_drain = 1'b0;
				expected_results.push_back(apply_list_cmd(taken));
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got.status      = rsp_if.status;
				got.found_index = rsp_if.found_index;
				got.length      = rsp_if.length;
				got.empty_res   = rsp_if.empty_res;
				got.full_res    = rsp_if.full_res;
				if (expected_results.size() == 0) begin
					note_failure($sformatf(
						"result with nothing outstanding: status %0b idx %0d len %0d",
						got.status, got.found_index, got.length));
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.found_index !== want.found_index
							|| got.length !== want.length || got.empty_res !== want.empty_res
							|| got.full_res !== want.full_res)
						note_failure($sformatf({
							"result mismatch: exp st %0b idx %0d len %0d e %0b f %0b, ",
							"got st %0b idx %0d len %0d e %0b f %0b"},
							want.status, want.found_index, want.length, want.empty_res,
							want.full_res, got.status, got.found_index, got.length,
							got.empty_res, got.full_res));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// run limit
	// ------------------------------------------------------------------
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		episode_t ep;
		int       rand_cnt;
		int       ep_len;
		int       r;
		bit       drain;

		// every input known from time zero
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.cmd      = CMD_INSERT;
		req_if.position = '0;
		req_if.value    = '0;
		rsp_if.ready    = 1'b0;
		sent_cnt        = 0;
		fail_cnt        = 0;
		model_len       = 0;

		// --- directed part: corners of every command on a short list ---
		plan_cmd(CMD_FIND,   0,   32'sd0, 1'b0);          // find on an empty list
		plan_cmd(CMD_DELETE, 1,   32'sd0, 1'b0);          // delete on an empty list
		plan_cmd(CMD_DELETE, 0,   32'sd0, 1'b0);          // delete at position zero
		plan_cmd(CMD_INSERT, 0,   32'sd7, 1'b0);          // insert at position zero
		plan_cmd(CMD_INSERT, 2,   32'sd7, 1'b0);          // insert past count+1
		plan_cmd(CMD_INSERT, 1,   32'sh7fff_ffff, 1'b0);  // first entry, largest value
		plan_cmd(CMD_INSERT, 1,   32'sh8000_0000, 1'b0);  // in front, smallest value
		plan_cmd(CMD_INSERT, 3,   -32'sd1, 1'b0);         // append at count+1
		plan_cmd(CMD_INSERT, 2,   32'sd0, 1'b0);          // into the middle
		plan_cmd(CMD_INSERT, 255, 32'sd9, 1'b0);          // far out of range
		plan_cmd(CMD_FIND,   255, 32'sh8000_0000, 1'b0);  // hit at index 0
		plan_cmd(CMD_FIND,   0,   -32'sd1, 1'b0);         // hit at the last index
		plan_cmd(CMD_FIND,   17,  32'sd12345, 1'b0);      // no match in a filled list
		plan_cmd(CMD_INSERT, 5,   -32'sd1, 1'b0);         // duplicate at the end
		plan_cmd(CMD_FIND,   0,   -32'sd1, 1'b0);         // first of two matches
		plan_cmd(CMD_DELETE, 6,   32'sd0, 1'b0);          // one past the end
		plan_cmd(CMD_DELETE, 5,   32'sd0, 1'b0);          // last entry
		plan_cmd(CMD_DELETE, 1,   32'sd0, 1'b0);          // first entry, rest shift down
		plan_cmd(CMD_DELETE, 255, 32'sd0, 1'b0);          // far out of range
		plan_cmd(CMD_FIND,   0,   32'sh7fff_ffff, 1'b0);  // moved entry still found
		plan_cmd(CMD_CLEAR,  0,   32'sd0, 1'b1);          // clear, after a full drain
		plan_cmd(CMD_FIND,   0,   -32'sd1, 1'b0);         // stale bits must not match
		plan_cmd(CMD_CLEAR,  200, 32'sd0, 1'b0);          // clear on an empty list
		plan_cmd(CMD_INSERT, 1,   32'sh5555_5555, 1'b0);

		// --- random part: stretches that grow, shrink, mix or fill the list ---
		rand_cnt = 0;
		ep       = EP_FILL;
		while (rand_cnt < RAND_ITEMS) begin
			ep_len = $urandom_range(20, 150);
			drain  = ($urandom_range(3) == 0);
			if (ep == EP_FILL) begin
				// fill to the brim, with a few finds along the way
				while (planned_vals.size() < DEPTH) begin
					if ($urandom_range(9) == 0)
						plan_cmd(CMD_FIND, $urandom_range(255), pick_value(1'b1), drain);
					else
						plan_cmd(CMD_INSERT, $urandom_range(1, planned_vals.size() + 1),
							pick_value(1'b0), drain);
					drain = 1'b0;
					rand_cnt++;
				end
				// full-list corners: rejected inserts, top index, deletes at both ends
				plan_cmd(CMD_INSERT, DEPTH + 1, pick_value(1'b0), 1'b0);
				plan_cmd(CMD_INSERT, 1, pick_value(1'b0), 1'b0);
				plan_cmd(CMD_FIND, 0, planned_vals[DEPTH - 1], 1'b0);
				plan_cmd(CMD_FIND, 0, $urandom, 1'b0);
				plan_cmd(CMD_DELETE, DEPTH + 1, 32'sd0, 1'b0);
				plan_cmd(CMD_DELETE, DEPTH, 32'sd0, 1'b0);
				plan_cmd(CMD_DELETE, 1, 32'sd0, 1'b0);
				rand_cnt += 7;
			end else begin
				for (int k = 0; k < ep_len; k++) begin
					plan_random_cmd(ep, drain);
					drain = 1'b0;
					rand_cnt++;
				end
			end
			r = $urandom_range(9);
			if (r == 0)
				ep = EP_FILL;
			else if (r < 4)
				ep = EP_GROW;
			else if (r < 7)
				ep = EP_SHRINK;
			else
				ep = EP_MIX;
		end
		total_cmds = pending_cmds.size();

		// reset, released away from the rising edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the last item to go out and its result to come back
		while (pending_cmds.size() != 0 || req_if.valid || expected_results.size() != 0)
			@(negedge clk);
		// quiet tail: anything arriving now is an extra result
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_cnt == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
